### rtl/tphm_pkg.sv
// Shared types, codes and constants of the heartbeat ping monitor.
package tphm_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int MASK_W         = 16;

  localparam int CMD_W     = 2;
  localparam int MTYPE_W   = 2;
  localparam int KIND_W    = 3;
  localparam int TIME_W    = 64;
  localparam int ID_W      = 8;
  localparam int PAYLOAD_W = 32;
  localparam int SEQ_W     = 16;
  localparam int NTASK_W   = 5;
  localparam int OWN_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 112;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MSG   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL  = 2'd2;

  // Message types.
  localparam logic [MTYPE_W-1:0] MSG_TEST  = 2'd0;
  localparam logic [MTYPE_W-1:0] MSG_PING  = 2'd1;
  localparam logic [MTYPE_W-1:0] MSG_ECHO  = 2'd2;
  localparam logic [MTYPE_W-1:0] MSG_OTHER = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO_REPLY   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PING_REQ     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LATE_ECHO    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID_ECHO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ONTIME_ECHO  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TASKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_INDEX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_ID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNTER = 3'd5;

  // Register reset values.
  localparam logic [NTASK_W-1:0]   NUM_TASKS_RST   = 5'd16;
  localparam logic [OWN_W-1:0]     OWN_INDEX_RST   = 4'd0;
  localparam logic [ID_W-1:0]      HOST_ID_RST     = 8'd0;
  localparam logic [CFG_DAT_W-1:0] TIMEOUT_RST     = 32'd1000000;
  localparam logic [CFG_DAT_W-1:0] INTERVAL_RST    = 32'd1000000;
  localparam logic [SEQ_W-1:0]     MAX_COUNTER_RST = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_SCAN   = 3'b100
  } tphm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic clear;
    logic emit_reply;
    logic emit_check;
    logic round_start;
    logic emit_ping;
  } tphm_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [MTYPE_W-1:0] msg_type;
    logic               round_due;
    logic               elig_empty;
    logic               elig_last;
    logic               out_free;
  } tphm_stat_t;

endpackage

### rtl/tphm_ctrl.sv
// Control state machine of the heartbeat ping monitor.
module tphm_ctrl
  import tphm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  tphm_stat_t stat,
  output tphm_ctl_t  ctl
);

  tphm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          ctl.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
          CMD_MSG: begin
            if (stat.msg_type == MSG_PING || stat.msg_type == MSG_ECHO) begin
              // Hold here until the output register can take the result.
              if (stat.out_free) begin
                ctl.emit_reply = (stat.msg_type == MSG_PING);
                ctl.emit_check = (stat.msg_type == MSG_ECHO);
                state_nxt      = ST_IDLE;
              end
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          CMD_POLL: begin
            if (stat.round_due) begin
              ctl.round_start = 1'b1;
              state_nxt       = ST_SCAN;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (stat.elig_empty) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          ctl.emit_ping = 1'b1;
          if (stat.elig_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit_reply || ctl.emit_check || ctl.emit_ping) |-> stat.out_free)
    else $error("result emitted while output register is occupied");

  a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.emit_reply, ctl.emit_check, ctl.emit_ping, ctl.latch}))
    else $error("conflicting datapath commands");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DECODE))
    else $error("accepted beat not followed by decode");

endmodule

### rtl/tphm_datapath.sv
// Datapath of the heartbeat ping monitor: registers, slot table and output register.
module tphm_datapath
  import tphm_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata,
  input  tphm_ctl_t              ctl,
  output tphm_stat_t             stat
);

  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int SCAN_SLOTS = (TASK_SLOTS < MASK_W) ? TASK_SLOTS : MASK_W;
  localparam int SCAN_W     = $clog2(SCAN_SLOTS);
  localparam int ENTRY_W    = TIME_W + SEQ_W;

  // Configuration registers.
  logic [NTASK_W-1:0]   num_tasks_r;
  logic [OWN_W-1:0]     own_index_r;
  logic [ID_W-1:0]      host_id_r;
  logic [CFG_DAT_W-1:0] timeout_r;
  logic [CFG_DAT_W-1:0] interval_r;
  logic [SEQ_W-1:0]     max_counter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tasks_r   <= NUM_TASKS_RST;
      own_index_r   <= OWN_INDEX_RST;
      host_id_r     <= HOST_ID_RST;
      timeout_r     <= TIMEOUT_RST;
      interval_r    <= INTERVAL_RST;
      max_counter_r <= MAX_COUNTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_TASKS:   num_tasks_r   <= cfg_wdata[NTASK_W-1:0];
        REG_OWN_INDEX:   own_index_r   <= cfg_wdata[OWN_W-1:0];
        REG_HOST_ID:     host_id_r     <= cfg_wdata[ID_W-1:0];
        REG_TIMEOUT:     timeout_r     <= cfg_wdata;
        REG_INTERVAL:    interval_r    <= cfg_wdata;
        REG_MAX_COUNTER: max_counter_r <= cfg_wdata[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat fields.
  logic [TIME_W-1:0]    in_now;
  logic [ID_W-1:0]      in_stask;
  logic [ID_W-1:0]      in_shost;
  logic [PAYLOAD_W-1:0] in_payload;
  logic [MASK_W-1:0]    in_mask;

  assign in_now     = in_tdata[63:0];
  assign in_stask   = in_tdata[71:64];
  assign in_shost   = in_tdata[79:72];
  assign in_payload = in_tdata[111:80];
  assign in_mask    = in_tdata[127:112];

  logic [CMD_W-1:0]     cmd_r;
  logic [MTYPE_W-1:0]   mtype_r;
  logic [TIME_W-1:0]    now_r;
  logic [ID_W-1:0]      stask_r;
  logic [ID_W-1:0]      shost_r;
  logic [PAYLOAD_W-1:0] payload_r;
  logic [MASK_W-1:0]    mask_r;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r     <= in_tuser[1:0];
      mtype_r   <= in_tuser[3:2];
      now_r     <= in_now;
      stask_r   <= in_stask;
      shost_r   <= in_shost;
      payload_r <= in_payload;
      mask_r    <= in_mask;
    end
  end

  // Slot table: send time and sequence number per slot, pending flags in flops.
  logic [ENTRY_W-1:0]    table_mem [TASK_SLOTS];
  logic [ENTRY_W-1:0]    rd_r;
  logic [TASK_SLOTS-1:0] seq_valid_r;
  logic [SEQ_W-1:0]      ping_seq_r;
  logic [TIME_W-1:0]     next_round_r;
  logic [SCAN_SLOTS-1:0] elig_r;

  // Lowest eligible slot of the current round.
  logic [SCAN_SLOTS-1:0] scan_onehot;
  logic [SCAN_W-1:0]     scan_idx;
  logic [SLOT_W-1:0]     scan_slot;
  logic [SEQ_W-1:0]      seq_inc;
  logic [SCAN_SLOTS-1:0] elig_new;

  assign scan_onehot = elig_r & (~elig_r + 1'b1);
  assign scan_slot   = SLOT_W'(scan_idx);
  assign seq_inc     = ping_seq_r + 1'b1;

  always_comb begin
    scan_idx = '0;
    for (int j = 0; j < SCAN_SLOTS; j++) begin
      if (scan_onehot[j]) begin
        scan_idx = scan_idx | SCAN_W'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SCAN_SLOTS; j++) begin
      elig_new[j] = (NTASK_W'(j) < num_tasks_r) && !mask_r[j] &&
                    (OWN_W'(j) != own_index_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      rd_r <= table_mem[in_stask[SLOT_W-1:0]];
    end
    if (ctl.emit_ping) begin
      table_mem[scan_slot] <= {now_r, ping_seq_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r  <= '0;
      ping_seq_r   <= '0;
      next_round_r <= '0;
      elig_r       <= '0;
    end else begin
      if (ctl.clear) begin
        seq_valid_r  <= '0;
        ping_seq_r   <= '0;
        next_round_r <= '0;
      end
      if (ctl.round_start) begin
        next_round_r <= now_r + TIME_W'(interval_r);
        elig_r       <= elig_new;
      end
      if (ctl.emit_ping) begin
        seq_valid_r[scan_slot] <= 1'b1;
        elig_r                 <= elig_r & ~scan_onehot;
        ping_seq_r             <= (seq_inc >= max_counter_r) ? '0 : seq_inc;
      end
    end
  end

  // Echo check against the entry read at accept time.
  logic [TIME_W-1:0] delay_w;
  logic              echo_ok;
  logic              echo_late;

  assign delay_w   = now_r - rd_r[ENTRY_W-1:SEQ_W];
  assign echo_late = delay_w > TIME_W'(timeout_r);
  assign echo_ok   = (stask_r < ID_W'(TASK_SLOTS)) && seq_valid_r[stask_r[SLOT_W-1:0]] &&
                     (payload_r == PAYLOAD_W'(rd_r[SEQ_W-1:0]));

  // Output register.
  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [ID_W-1:0]      out_host_r;
  logic [ID_W-1:0]      out_task_r;
  logic [PAYLOAD_W-1:0] out_payload_r;
  logic [TIME_W-1:0]    out_delay_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_reply || ctl.emit_check || ctl.emit_ping) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_reply) begin
      out_kind_r    <= KIND_ECHO_REPLY;
      out_host_r    <= shost_r;
      out_task_r    <= stask_r;
      out_payload_r <= payload_r;
      out_delay_r   <= '0;
      out_last_r    <= 1'b1;
    end else if (ctl.emit_check) begin
      out_kind_r    <= !echo_ok ? KIND_INVALID_ECHO :
                       (echo_late ? KIND_LATE_ECHO : KIND_ONTIME_ECHO);
      out_host_r    <= shost_r;
      out_task_r    <= stask_r;
      out_payload_r <= payload_r;
      out_delay_r   <= echo_ok ? delay_w : '0;
      out_last_r    <= 1'b1;
    end else if (ctl.emit_ping) begin
      out_kind_r    <= KIND_PING_REQ;
      out_host_r    <= host_id_r;
      out_task_r    <= ID_W'(scan_idx);
      out_payload_r <= PAYLOAD_W'(ping_seq_r);
      out_delay_r   <= '0;
      out_last_r    <= ((elig_r & ~scan_onehot) == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_delay_r, out_payload_r, out_task_r, out_host_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign stat.cmd        = cmd_r;
  assign stat.msg_type   = mtype_r;
  assign stat.round_due  = now_r >= next_round_r;
  assign stat.elig_empty = (elig_r == '0);
  assign stat.elig_last  = ((elig_r & ~scan_onehot) == '0);
  assign stat.out_free   = !out_valid_r || out_tready;

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (seq_valid_r == '0) && (ping_seq_r == '0) && (next_round_r == '0))
    else $error("clear left pending state behind");

  a_ping_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_ping |-> (elig_r != '0))
    else $error("ping emitted with no eligible slot");

  a_ping_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_ping |=> out_valid_r && (out_kind_r == KIND_PING_REQ))
    else $error("ping request not loaded into output register");

endmodule

### rtl/task_heartbeat_ping_monitor_top.sv
// Top level of the heartbeat ping monitor: controller plus datapath.
// Flow: a beat is accepted in idle, then decoded; a reply or echo check is registered from decode,
// and a round's pings are registered from the scan state entered after decode. A result waits while
// the output register is full, and a ping round stretches while the output register is held; the
// controller takes no new beat until it is back in idle.
// Reset (sync, active low) loads register defaults and clears pending flags, counter and timer.
module task_heartbeat_ping_monitor_top
  import tphm_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // now, sender_task, sender_host, msg_payload, sleeping_mask
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd, msg_type
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // dest_host, dest_task, out_payload, delay
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // kind
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata
);

  tphm_ctl_t  ctl;
  tphm_stat_t stat;

  tphm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  tphm_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .stat       (stat)
  );

endmodule

### test/tb_task_heartbeat_ping_monitor_top.sv
// Self-checking testbench for the heartbeat ping monitor: table-driven and random stream beats.
`timescale 1ns / 100ps

module tb_task_heartbeat_ping_monitor_top;
  import tphm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  localparam int RST_CYCLES = 7;
  localparam int TAIL_CYCLES = 40;
  localparam int N_PHASES = 6;
  localparam int BEATS_PER_PHASE = 80;
  localparam int DIR_ROWS = 22;
  localparam int SHOWN_FAULTS = 10;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [MTYPE_W-1:0]   mtype;
    logic [TIME_W-1:0]    now;
    logic [ID_W-1:0]      stask;
    logic [ID_W-1:0]      shost;
    logic [PAYLOAD_W-1:0] payload;
    logic [MASK_W-1:0]    mask;
  } hb_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      dhost;
    logic [ID_W-1:0]      dtask;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    delay;
    logic                 last;
  } hb_msg_t;

  // How a table row is checked: by the predictor, as silent, or against one typed result.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_t;

  // Typed results always carry a zero delay and close their beat.
  typedef struct packed {
    hb_beat_t             beat;
    row_chk_t             chk;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      dhost;
    logic [ID_W-1:0]      dtask;
    logic [PAYLOAD_W-1:0] payload;
  } dir_row_t;

  typedef struct packed {
    logic [NTASK_W-1:0]   ntasks;
    logic [OWN_W-1:0]     own;
    logic [ID_W-1:0]      host;
    logic [CFG_DAT_W-1:0] timeout;
    logic [CFG_DAT_W-1:0] interval;
    logic [SEQ_W-1:0]     maxcnt;
  } cfg_set_t;

  // Default registers: 16 slots, own slot 0, timeout and interval of 1000000.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{CMD_MSG, MSG_PING, T_MAX, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF},
      CHK_ONE, KIND_ECHO_REPLY, 8'hFF, 8'hFF, 32'hFFFF_FFFF},
    '{'{CMD_MSG, MSG_PING, 64'd0, 8'h00, 8'h00, 32'h0, 16'h0},
      CHK_ONE, KIND_ECHO_REPLY, 8'h00, 8'h00, 32'h0},
    '{'{CMD_MSG, MSG_TEST, 64'd10, 8'h01, 8'h02, 32'h1234, 16'h0}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_MSG, MSG_OTHER, 64'd11, 8'h02, 8'h03, 32'h5678, 16'h0}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_UNUSED, MSG_PING, 64'd12, 8'h04, 8'h05, 32'h9, 16'h0}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    // Echo to a slot with nothing pending.
    '{'{CMD_MSG, MSG_ECHO, 64'd13, 8'd5, 8'd9, 32'h0, 16'h0},
      CHK_ONE, KIND_INVALID_ECHO, 8'd9, 8'd5, 32'h0},
    // Sender beyond the task slots.
    '{'{CMD_MSG, MSG_ECHO, 64'd14, 8'd200, 8'd3, 32'h0, 16'h0},
      CHK_ONE, KIND_INVALID_ECHO, 8'd3, 8'd200, 32'h0},
    '{'{CMD_POLL, MSG_TEST, 64'd0, 8'h0, 8'h0, 32'h0, 16'h0}, CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_MSG, MSG_ECHO, 64'd500, 8'd3, 8'd7, 32'd2, 16'h0}, CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_MSG, MSG_ECHO, 64'd500, 8'd3, 8'd7, 32'd2, 16'h0}, CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_MSG, MSG_ECHO, 64'd1000000, 8'd3, 8'd7, 32'd2, 16'h0},
      CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_MSG, MSG_ECHO, 64'd1000001, 8'd3, 8'd7, 32'd2, 16'h0},
      CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    // Wrong sequence number for a pending slot.
    '{'{CMD_MSG, MSG_ECHO, 64'd600, 8'd3, 8'd7, 32'd3, 16'h0},
      CHK_ONE, KIND_INVALID_ECHO, 8'd7, 8'd3, 32'd3},
    '{'{CMD_MSG, MSG_ECHO, 64'd20, 8'd15, 8'd1, 32'd14, 16'h0}, CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_POLL, MSG_TEST, 64'd999999, 8'h0, 8'h0, 32'h0, 16'h0}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_POLL, MSG_TEST, 64'd1000000, 8'h0, 8'h0, 32'h0, 16'hAAAA},
      CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_CLEAR, MSG_TEST, 64'd0, 8'h0, 8'h0, 32'h0, 16'h0}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_MSG, MSG_ECHO, 64'd30, 8'd2, 8'h11, 32'd15, 16'h0},
      CHK_ONE, KIND_INVALID_ECHO, 8'h11, 8'd2, 32'd15},
    // Empty round at the top of time: the next round time wraps around.
    '{'{CMD_POLL, MSG_TEST, T_MAX, 8'h0, 8'h0, 32'h0, 16'hFFFF}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_POLL, MSG_TEST, 64'd999998, 8'h0, 8'h0, 32'h0, 16'h0}, CHK_NONE, 3'd0, 8'h0, 8'h0, 32'h0},
    '{'{CMD_POLL, MSG_TEST, 64'd999999, 8'h0, 8'h0, 32'h0, 16'hFFF7},
      CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0},
    // Echo stamped before its ping: the delay wraps.
    '{'{CMD_MSG, MSG_ECHO, 64'd5, 8'd3, 8'h00, 32'd0, 16'h0}, CHK_MODEL, 3'd0, 8'h0, 8'h0, 32'h0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DAT_W-1:0]   cfg_wdata;

  // Register shadows and the monitor's table as the predictor sees them.
  logic [NTASK_W-1:0]   num_tasks;
  logic [OWN_W-1:0]     own_idx;
  logic [ID_W-1:0]      host_id;
  logic [CFG_DAT_W-1:0] timeout_us;
  logic [CFG_DAT_W-1:0] interval_us;
  logic [SEQ_W-1:0]     max_cnt;
  logic [TIME_W-1:0]    sent_at [TASK_SLOTS_DEF];
  logic [SEQ_W-1:0]     seq_owed [TASK_SLOTS_DEF];
  logic                 ping_open [TASK_SLOTS_DEF];
  logic [SEQ_W-1:0]     seq_next;
  logic [TIME_W-1:0]    round_due_at;

  hb_msg_t step_out [$];
  hb_msg_t owed_msgs [$];

  int idle_in = 0;
  int stall_out = 0;
  int faults = 0;
  int beats_in = 0;
  int beats_out = 0;

  task_heartbeat_ping_monitor_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void wipe_table();
    for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
      sent_at[i] = '0;
      seq_owed[i] = '0;
      ping_open[i] = 1'b0;
    end
    seq_next = '0;
    round_due_at = '0;
  endfunction

  // Works out the result beats of one input beat into step_out and updates the table.
  function automatic void heartbeat_step(input hb_beat_t b);
    hb_msg_t m;
    logic [TIME_W-1:0] gap;
    int span;
    logic [3:0] slot;
    step_out.delete();
    m = '0;
    slot = b.stask[3:0];
    case (b.cmd)
      CMD_CLEAR: wipe_table();
      CMD_MSG: begin
        m.dhost = b.shost;
        m.dtask = b.stask;
        m.payload = b.payload;
        if (b.mtype == MSG_PING) begin
          m.kind = KIND_ECHO_REPLY;
          step_out.push_back(m);
        end else if (b.mtype == MSG_ECHO) begin
          if (b.stask < ID_W'(TASK_SLOTS_DEF) && ping_open[slot] &&
              b.payload == {16'h0, seq_owed[slot]}) begin
            gap = b.now - sent_at[slot];
            m.delay = gap;
            m.kind = (gap > {32'h0, timeout_us}) ? KIND_LATE_ECHO : KIND_ONTIME_ECHO;
          end else begin
            m.kind = KIND_INVALID_ECHO;
          end
          step_out.push_back(m);
        end
      end
      CMD_POLL: begin
        if (b.now >= round_due_at) begin
          span = (int'(num_tasks) > TASK_SLOTS_DEF) ? TASK_SLOTS_DEF : int'(num_tasks);
          for (int i = 0; i < span; i++) begin
            if (!b.mask[i] && i != int'(own_idx)) begin
              m.kind = KIND_PING_REQ;
              m.dhost = host_id;
              m.dtask = ID_W'(i);
              m.payload = {16'h0, seq_next};
              step_out.push_back(m);
              sent_at[i] = b.now;
              seq_owed[i] = seq_next;
              ping_open[i] = 1'b1;
              seq_next = seq_next + 1'b1;
              if (seq_next >= max_cnt) seq_next = '0;
            end
          end
          round_due_at = b.now + {32'h0, interval_us};
        end
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // Mostly well-formed traffic: due polls and echoes that answer a pending ping.
  function automatic hb_beat_t make_beat();
    hb_beat_t b;
    int pick;
    int slot;
    int s;
    logic [TIME_W-1:0] lag;
    b.cmd = CMD_MSG;
    b.mtype = MSG_PING;
    b.now = {$urandom, $urandom};
    b.stask = ID_W'($urandom);
    b.shost = ID_W'($urandom);
    b.payload = $urandom;
    b.mask = MASK_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      b.cmd = CMD_POLL;
      b.now = round_due_at + TIME_W'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: b.mask = '0;
        1: b.mask = MASK_W'($urandom & $urandom);
        2: b.mask = MASK_W'($urandom | $urandom);
        default: ;
      endcase
    end else if (pick < 17) begin
      b.cmd = CMD_POLL;
    end else if (pick < 57) begin
      slot = -1;
      for (int k = 0; k < 8 && slot < 0; k++) begin
        s = $urandom_range(0, TASK_SLOTS_DEF - 1);
        if (ping_open[s]) slot = s;
      end
      if (slot >= 0) begin
        b.mtype = MSG_ECHO;
        b.stask = ID_W'(slot);
        b.payload = {16'h0, seq_owed[slot]};
        case ($urandom_range(0, 4))
          0: lag = TIME_W'($urandom_range(0, timeout_us));
          1: lag = {32'h0, timeout_us};
          2: lag = {32'h0, timeout_us} + 1'b1;
          3: lag = {$urandom, $urandom};
          default: lag = TIME_W'($urandom_range(0, 50));
        endcase
        b.now = sent_at[slot] + lag;
        if ($urandom_range(0, 9) == 0) b.payload = b.payload ^ (32'h1 << $urandom_range(0, 31));
      end
    end else if (pick < 70) begin
      b.mtype = MSG_ECHO;
      if ($urandom_range(0, 1) == 0) b.stask = ID_W'($urandom_range(0, TASK_SLOTS_DEF - 1));
      if ($urandom_range(0, 1) == 0) b.payload = $urandom_range(0, 20);
    end else if (pick < 82) begin
      b.mtype = MSG_PING;
    end else if (pick < 90) begin
      b.mtype = ($urandom_range(0, 1) == 0) ? MSG_TEST : MSG_OTHER;
    end else if (pick < 94) begin
      b.cmd = CMD_UNUSED;
      b.mtype = MTYPE_W'($urandom);
    end else if (pick < 97) begin
      b.cmd = CMD_CLEAR;
    end else begin
      b.mtype = MTYPE_W'($urandom);
    end
    return b;
  endfunction

  // Starts and ends at a falling edge; valid stays high when the next beat follows at once.
  task automatic send_beat(input hb_beat_t b, input row_chk_t chk, input hb_msg_t typed);
    while ($urandom_range(0, 99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b.mask, b.payload, b.shost, b.stask, b.now};
    in_tuser <= {b.mtype, b.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    heartbeat_step(b);
    beats_in++;
    if (chk == CHK_MODEL) begin
      foreach (step_out[k]) owed_msgs.push_back(step_out[k]);
    end else if (chk == CHK_ONE) begin
      owed_msgs.push_back(typed);
    end
    @(negedge clk);
  endtask

  task automatic drain_results(input int tail);
    in_tvalid <= 1'b0;
    while (owed_msgs.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NUM_TASKS:   num_tasks = val[NTASK_W-1:0];
      REG_OWN_INDEX:   own_idx = val[OWN_W-1:0];
      REG_HOST_ID:     host_id = val[ID_W-1:0];
      REG_TIMEOUT:     timeout_us = val;
      REG_INTERVAL:    interval_us = val;
      REG_MAX_COUNTER: max_cnt = val[SEQ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_regs(input cfg_set_t c);
    write_reg(REG_NUM_TASKS, CFG_DAT_W'(c.ntasks));
    write_reg(REG_OWN_INDEX, CFG_DAT_W'(c.own));
    write_reg(REG_HOST_ID, CFG_DAT_W'(c.host));
    write_reg(REG_TIMEOUT, c.timeout);
    write_reg(REG_INTERVAL, c.interval);
    write_reg(REG_MAX_COUNTER, CFG_DAT_W'(c.maxcnt));
    cfg_we <= 1'b0;
  endtask

  // Receiver side: random backpressure at the rate of the current phase.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= stall_out);
    end
  end

  always @(posedge clk) begin
    hb_msg_t got;
    hb_msg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[47:16],
              out_tdata[111:48], out_tlast};
      beats_out++;
      if (owed_msgs.size() == 0) begin
        faults++;
        if (faults <= SHOWN_FAULTS) begin
          $display("%0t: result beat with nothing owed", $realtime);
          $display("  got kind %0d host %h task %h pay %h dly %h last %b",
                   got.kind, got.dhost, got.dtask, got.payload, got.delay, got.last);
        end
      end else begin
        want = owed_msgs.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= SHOWN_FAULTS) begin
            $display("%0t: mismatch", $realtime);
            $display("  exp kind %0d host %h task %h pay %h dly %h last %b",
                     want.kind, want.dhost, want.dtask, want.payload, want.delay, want.last);
            $display("  got kind %0d host %h task %h pay %h dly %h last %b",
                     got.kind, got.dhost, got.dtask, got.payload, got.delay, got.last);
          end
        end
      end
    end
  end

  initial begin
    hb_beat_t b;
    hb_msg_t typed;
    cfg_set_t c;
    int counted;
    bit paused;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    num_tasks = NUM_TASKS_RST;
    own_idx = OWN_INDEX_RST;
    host_id = HOST_ID_RST;
    timeout_us = TIMEOUT_RST;
    interval_us = INTERVAL_RST;
    max_cnt = MAX_COUNTER_RST;
    wipe_table();
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain_results(TAIL_CYCLES);
        case (p)
          1: c = '{5'd16, 4'd15, 8'hFF, 32'd0, 32'd0, 16'd1};
          2: c = '{5'd1, 4'd5, 8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0};
          3: c = '{5'd31, 4'd7, 8'h01, 32'd1000, 32'd50, 16'd7};
          4: c = '{NTASK_W'($urandom_range(1, 16)), OWN_W'($urandom), ID_W'($urandom),
                   $urandom_range(0, 5000), $urandom_range(0, 3000),
                   SEQ_W'($urandom_range(1, 65535))};
          default: c = '{5'd9, 4'd3, 8'hC3, 32'd1000000, 32'd1000000, 16'hFFFF};
        endcase
        load_regs(c);
      end
      idle_in = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 23 : 0;
      stall_out = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 23 : 0;

      if (p == 0) begin
        for (int r = 0; r < DIR_ROWS; r++) begin
          typed = '{DIR_TAB[r].kind, DIR_TAB[r].dhost, DIR_TAB[r].dtask, DIR_TAB[r].payload,
                    64'd0, 1'b1};
          send_beat(DIR_TAB[r].beat, DIR_TAB[r].chk, typed);
        end
      end

      counted = 0;
      paused = 1'b0;
      while (counted < BEATS_PER_PHASE) begin
        b = make_beat();
        send_beat(b, CHK_MODEL, '0);
        counted++;
        // Halfway through, hold the sender until every owed result is out.
        if (!paused && counted == BEATS_PER_PHASE / 2) begin
          drain_results(0);
          paused = 1'b1;
        end
      end
    end

    drain_results(TAIL_CYCLES);
    if (owed_msgs.size() != 0)
      $display("Results still owed at the end: %0d", owed_msgs.size());
    $display("Run sent %0d input beats and checked %0d result beats over six register settings,",
             beats_in, beats_out);
    $display("with free-flowing, idling and stalling stream sides; %0d mismatches seen.", faults);
    if (faults == 0 && owed_msgs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/tphm_pkg.sv
rtl/tphm_ctrl.sv
rtl/tphm_datapath.sv
rtl/task_heartbeat_ping_monitor_top.sv
test/tb_task_heartbeat_ping_monitor_top.sv
